### sv/assert_macros.svh
// Assertion macros used by the checker file of the classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ftc_pkg.sv
// Types, codes and constants shared by the five-tuple classifier modules.
`default_nettype none

package ftc_pkg;

  localparam int unsigned MaxRulesDef = 64;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_GET      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_RUN  = 2'd1,
    CTL_WAIT = 2'd2
  } ctl_e;

  // One request on the input channel.
  typedef struct packed {
    op_e         opcode;
    logic [63:0] rule_id;
    logic [31:0] key_src_ip;
    logic [31:0] key_dst_ip;
    logic [15:0] key_src_port;
    logic [15:0] key_dst_port;
    logic [7:0]  key_protocol;
    logic [3:0]  rule_action;
  } in_t;

  // One response on the output channel.
  typedef struct packed {
    status_e     status;
    logic [3:0]  result_action;
    logic        hit;
    logic [63:0] assigned_id;
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [7:0]  out_protocol;
    logic [6:0]  count_of_rules;
  } out_t;

  // Match fields and action of a rule; also what a probe picks up.
  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } fields_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] id;
    fields_t     f;
  } rule_t;

  // Probe token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic    active;
    logic    found;
    fields_t cap;
  } token_t;

  // Request held steady for every cell while a probe is under way.
  typedef struct packed {
    in_t         req;
    logic [63:0] new_id;
  } bcast_t;

endpackage

`default_nettype wire

### sv/ftc_cell.sv
// One rule slot of the classifier row, with its stage of the probe path.
`default_nettype none

module ftc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ftc_pkg::bcast_t bc_i,
  input  ftc_pkg::token_t tok_i,
  output ftc_pkg::token_t tok_o,
  input  ftc_pkg::rule_t  next_rule_i,
  output ftc_pkg::rule_t  rule_o
);
  import ftc_pkg::*;

  logic        valid_q, valid_d;
  logic [63:0] id_q, id_d;
  fields_t     f_q, f_d;
  token_t      tok_q, tok_d;
  logic        id_hit;
  logic        cls_hit;

  assign id_hit  = valid_q && (id_q == bc_i.req.rule_id);
  // A zero field in the rule matches any packet value.
  assign cls_hit = valid_q &&
                   (f_q.src_ip   == '0 || f_q.src_ip   == bc_i.req.key_src_ip) &&
                   (f_q.dst_ip   == '0 || f_q.dst_ip   == bc_i.req.key_dst_ip) &&
                   (f_q.sport    == '0 || f_q.sport    == bc_i.req.key_src_port) &&
                   (f_q.dport    == '0 || f_q.dport    == bc_i.req.key_dst_port) &&
                   (f_q.protocol == '0 || f_q.protocol == bc_i.req.key_protocol);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    f_d     = f_q;
    tok_d   = tok_i;
    if (tok_i.active) begin
      case (bc_i.req.opcode)
        OP_ADD: begin
          // The first free slot is the one just past the installed rules.
          if (!tok_i.found && !valid_q) begin
            valid_d         = 1'b1;
            id_d            = bc_i.new_id;
            f_d.action      = bc_i.req.rule_action;
            f_d.src_ip      = bc_i.req.key_src_ip;
            f_d.dst_ip      = bc_i.req.key_dst_ip;
            f_d.sport       = bc_i.req.key_src_port;
            f_d.dport       = bc_i.req.key_dst_port;
            f_d.protocol    = bc_i.req.key_protocol;
            tok_d.found     = 1'b1;
          end
        end
        OP_REMOVE: begin
          // From the removed slot onwards every cell takes its upper neighbour.
          if (tok_i.found || id_hit) begin
            valid_d     = next_rule_i.valid;
            id_d        = next_rule_i.id;
            f_d         = next_rule_i.f;
            tok_d.found = 1'b1;
          end
        end
        OP_CLASSIFY: begin
          if (!tok_i.found && cls_hit) begin
            tok_d.found      = 1'b1;
            tok_d.cap.action = f_q.action;
          end
        end
        OP_GET: begin
          if (!tok_i.found && id_hit) begin
            tok_d.found = 1'b1;
            tok_d.cap   = f_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    f_q  <= f_d;
  end

  assign tok_o        = tok_q;
  assign rule_o.valid = valid_q;
  assign rule_o.id    = id_q;
  assign rule_o.f     = f_q;

endmodule

`default_nettype wire

### sv/ftc_chain.sv
// Row of rule cells linked by the probe path and the shift path.
`default_nettype none

module ftc_chain #(
  parameter int unsigned MaxRules = ftc_pkg::MaxRulesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ftc_pkg::bcast_t bc_i,
  input  ftc_pkg::token_t head_i,
  output ftc_pkg::token_t tail_o
);
  import ftc_pkg::*;

  token_t tok  [MaxRules+1];
  rule_t  rule [MaxRules+1];

  assign tok[0]         = head_i;
  // Beyond the last cell there is only an empty slot.
  assign rule[MaxRules] = '0;

  for (genvar i = 0; i < MaxRules; i++) begin : g_cell
    ftc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bc_i        (bc_i),
      .tok_i       (tok[i]),
      .tok_o       (tok[i+1]),
      .next_rule_i (rule[i+1]),
      .rule_o      (rule[i])
    );
  end

  assign tail_o = tok[MaxRules];

endmodule

`default_nettype wire

### sv/five_tuple_first_match_classifier.sv
// Top level of the five-tuple first-match classifier.
//
//   Channel  Direction  Payload         Handshake
//   in       input      ftc_pkg::in_t   in_valid_i / in_stall_o
//   out      output     ftc_pkg::out_t  out_valid_o / out_stall_i
//
// Each request holds the block from acceptance until its result moves to the
// output register: a probe token walks the row of rule cells one cell per
// cycle, from the first cell to the last.
// Reset clears every slot's valid bit at once; no clearing pass is needed.
// A new request is taken while an earlier response still waits in the output
// register; a finished result waits in a holding register for it to drain.
`default_nettype none

module five_tuple_first_match_classifier #(
  parameter int unsigned MaxRules = ftc_pkg::MaxRulesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ftc_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ftc_pkg::out_t out_rsp_o
);
  import ftc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRules + 1);

  ctl_e            ctl_q, ctl_d;
  in_t             req_q, req_d;
  logic            start_q, start_d;
  logic [63:0]     next_id_q, next_id_d;
  logic [CntW-1:0] count_q, count_d;
  out_t            pend_q, pend_d;
  out_t            rsp_q, rsp_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;
  bcast_t          bc;
  token_t          head;
  token_t          tail;

  // The block is busy whenever a probe or a finished result is in flight.
  assign in_stall_o = (ctl_q != CTL_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Every cell sees the held request and the id an add would hand out.
  assign bc.req    = req_q;
  assign bc.new_id = next_id_q;

  // A fresh token enters the first cell in the cycle after acceptance.
  assign head.active = start_q;
  assign head.found  = 1'b0;
  assign head.cap    = '0;

  ftc_chain #(
    .MaxRules (MaxRules)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bc_i   (bc),
    .head_i (head),
    .tail_o (tail)
  );

  always_comb begin
    ctl_d       = ctl_q;
    req_d       = req_q;
    start_d     = 1'b0;
    next_id_d   = next_id_q;
    count_d     = count_q;
    pend_d      = pend_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (ctl_q)
      CTL_IDLE: begin
        if (accept) begin
          req_d   = in_req_i;
          start_d = 1'b1;
          ctl_d   = CTL_RUN;
        end
      end
      CTL_RUN: begin
        // The token leaving the last cell carries the verdict of the row.
        if (tail.active) begin
          pend_d               = '0;
          pend_d.status        = ST_OK;
          pend_d.result_action = tail.cap.action;
          pend_d.out_src_ip    = tail.cap.src_ip;
          pend_d.out_dst_ip    = tail.cap.dst_ip;
          pend_d.out_src_port  = tail.cap.sport;
          pend_d.out_dst_port  = tail.cap.dport;
          pend_d.out_protocol  = tail.cap.protocol;
          case (req_q.opcode)
            OP_ADD: begin
              if (tail.found) begin
                pend_d.assigned_id = next_id_q;
                next_id_d          = next_id_q + 64'd1;
                count_d            = count_q + CntW'(1);
              end else begin
                pend_d.status = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (tail.found) begin
                count_d = count_q - CntW'(1);
              end else begin
                pend_d.status = ST_NOT_FOUND;
              end
            end
            OP_CLASSIFY: begin
              pend_d.hit = tail.found;
            end
            OP_GET: begin
              if (!tail.found) begin
                pend_d.status = ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
          pend_d.count_of_rules = 7'(count_d);
          ctl_d                 = CTL_WAIT;
        end
      end
      CTL_WAIT: begin
        if (out_free) begin
          rsp_d       = pend_q;
          out_valid_d = 1'b1;
          ctl_d       = CTL_IDLE;
        end
      end
      default: begin
        ctl_d = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_IDLE;
      start_q     <= 1'b0;
      next_id_q   <= 64'd1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      start_q     <= start_d;
      next_id_q   <= next_id_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    rsp_q  <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

### sv/ftc_checker.sv
// Port-level checker for the five-tuple classifier, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module ftc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input ftc_pkg::out_t out_rsp_o
);
  import ftc_pkg::*;

  logic in_take;
  logic rsp_wait;
  logic rsp_hit;
  logic rsp_full;
  logic rsp_miss;
  logic full_clean;
  logic miss_clean;

  assign in_take    = in_valid_i && !in_stall_o;
  assign rsp_wait   = out_valid_o && out_stall_i;
  assign rsp_hit    = out_valid_o && out_rsp_o.hit;
  assign rsp_full   = out_valid_o && (out_rsp_o.status == ST_FULL);
  assign rsp_miss   = out_valid_o && (out_rsp_o.status == ST_NOT_FOUND);
  assign full_clean = (out_rsp_o.assigned_id == 64'd0) && !out_rsp_o.hit;
  assign miss_clean = (out_rsp_o.result_action == 4'd0) && (out_rsp_o.out_src_ip == 32'd0);

  // A request is worked on alone, so the input closes right after acceptance.
  `FTC_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall_o, "input open after accept")

  // A response held back by the receiver stays put.
  `FTC_ASSERT_NEXT(a_rsp_held, rsp_wait, out_valid_o && $stable(out_rsp_o), "stalled response changed")

  // Only a successful classify reports a hit.
  `FTC_ASSERT_NOW(a_hit_ok, rsp_hit, out_rsp_o.status == ST_OK, "hit with error status")

  // A refused add hands out no id.
  `FTC_ASSERT_NOW(a_full_no_id, rsp_full, full_clean, "id given on full table")

  // A miss on remove or get returns no rule contents.
  `FTC_ASSERT_NOW(a_miss_empty, rsp_miss, miss_clean, "rule data on miss")

endmodule

bind five_tuple_first_match_classifier ftc_checker u_ftc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

### tb/sv/five_tuple_first_match_classifier_test.sv
// Self-checking testbench for the five-tuple first-match classifier.
`timescale 1ns / 1ps

module five_tuple_first_match_classifier_test;
  import ftc_pkg::*;

  localparam int unsigned MAX_RULES = MaxRulesDef;

  // One installed rule as the predictor keeps it; queue order is match order.
  typedef struct packed {
    logic [63:0] id;
    fields_t     f;
  } live_rule_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_rsp_o;

  // Predictor state: the rule list in insertion order and the id counter.
  live_rule_t  rule_tbl[$];
  logic [63:0] id_counter = 64'd1;

  // Responses predicted for accepted requests, oldest first.
  out_t awaited_rsp_q[$];
  out_t want_rsp;

  int unsigned error_count = 0;

  // When clear, neither the request side nor the response side idles.
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned stall_roll;

  five_tuple_first_match_classifier #(
    .MaxRules(MAX_RULES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor of the rule table.
  // ---------------------------------------------------------------------------

  // Returns the position of the earliest rule carrying the id, or -1.
  function automatic int find_rule(logic [63:0] id);
    int pos;
    pos = -1;
    for (int i = 0; i < rule_tbl.size(); i++) begin
      if (pos < 0 && rule_tbl[i].id == id) begin
        pos = i;
      end
    end
    return pos;
  endfunction

  // A rule covers a packet when each of its nonzero fields equals the packet's.
  function automatic bit covers(fields_t rf, in_t p);
    return (rf.src_ip == '0 || rf.src_ip == p.key_src_ip) &&
           (rf.dst_ip == '0 || rf.dst_ip == p.key_dst_ip) &&
           (rf.sport == '0 || rf.sport == p.key_src_port) &&
           (rf.dport == '0 || rf.dport == p.key_dst_port) &&
           (rf.protocol == '0 || rf.protocol == p.key_protocol);
  endfunction

  // Applies one request to the predicted table and returns the response it
  // should produce. Every field not named by the operation stays zero.
  function automatic out_t rule_table_step(in_t r);
    out_t       rsp;
    live_rule_t nr;
    int         pos;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.opcode)
      OP_ADD: begin
        if (rule_tbl.size() >= MAX_RULES) begin
          rsp.status = ST_FULL;
        end else begin
          nr.id = id_counter;
          nr.f.action = r.rule_action;
          nr.f.src_ip = r.key_src_ip;
          nr.f.dst_ip = r.key_dst_ip;
          nr.f.sport = r.key_src_port;
          nr.f.dport = r.key_dst_port;
          nr.f.protocol = r.key_protocol;
          rule_tbl.insert(rule_tbl.size(), nr);
          rsp.assigned_id = id_counter;
          id_counter = id_counter + 64'd1;
        end
      end
      OP_REMOVE: begin
        pos = find_rule(r.rule_id);
        if (pos < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rule_tbl.delete(pos);
        end
      end
      OP_CLASSIFY: begin
        for (int i = 0; i < rule_tbl.size(); i++) begin
          if (!rsp.hit && covers(rule_tbl[i].f, r)) begin
            rsp.hit = 1'b1;
            rsp.result_action = rule_tbl[i].f.action;
          end
        end
      end
      default: begin
        pos = find_rule(r.rule_id);
        if (pos < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rsp.result_action = rule_tbl[pos].f.action;
          rsp.out_src_ip = rule_tbl[pos].f.src_ip;
          rsp.out_dst_ip = rule_tbl[pos].f.dst_ip;
          rsp.out_src_port = rule_tbl[pos].f.sport;
          rsp.out_dst_port = rule_tbl[pos].f.dport;
          rsp.out_protocol = rule_tbl[pos].f.protocol;
        end
      end
    endcase
    rsp.count_of_rules = 7'(rule_tbl.size());
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Random values for requests.
  // ---------------------------------------------------------------------------

  // A value of the given width, biased towards the extremes.
  function automatic logic [31:0] rand_value(int unsigned bits);
    logic [31:0] mask;
    mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    case ($urandom_range(0, 9))
      0: return mask;
      1: return 32'd1;
      2: return 32'd0;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic logic [63:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  // Random match fields; with wildcards on, each field is zero a third of the time.
  function automatic fields_t random_fields(bit with_wild);
    fields_t f;
    f.action = 4'($urandom_range(0, 15));
    f.src_ip = rand_value(32);
    f.dst_ip = rand_value(32);
    f.sport = 16'(rand_value(16));
    f.dport = 16'(rand_value(16));
    f.protocol = 8'(rand_value(8));
    if (with_wild) begin
      if ($urandom_range(0, 2) == 0) f.src_ip = '0;
      if ($urandom_range(0, 2) == 0) f.dst_ip = '0;
      if ($urandom_range(0, 2) == 0) f.sport = '0;
      if ($urandom_range(0, 2) == 0) f.dport = '0;
      if ($urandom_range(0, 2) == 0) f.protocol = '0;
    end
    return f;
  endfunction

  function automatic in_t make_req(op_e op, logic [63:0] id, fields_t f);
    in_t r;
    r.opcode = op;
    r.rule_id = id;
    r.key_src_ip = f.src_ip;
    r.key_dst_ip = f.dst_ip;
    r.key_src_port = f.sport;
    r.key_dst_port = f.dport;
    r.key_protocol = f.protocol;
    r.rule_action = f.action;
    return r;
  endfunction

  // Mostly an installed id; otherwise one that is likely absent.
  function automatic logic [63:0] pick_id();
    if (rule_tbl.size() > 0 && $urandom_range(0, 3) != 0) begin
      return rule_tbl[$urandom_range(0, rule_tbl.size() - 1)].id;
    end
    case ($urandom_range(0, 4))
      0: return rand_id();
      1: return id_counter;
      2: return 64'd0;
      3: return '1;
      default: return 64'($urandom_range(1, 32'(id_counter)));
    endcase
  endfunction

  // Mostly a packet built to hit an installed rule, sometimes with one field
  // nudged so that it just misses; otherwise a random packet.
  function automatic fields_t pick_packet();
    fields_t p;
    fields_t rf;
    p = random_fields(1'b0);
    if (rule_tbl.size() > 0 && $urandom_range(0, 9) < 7) begin
      rf = rule_tbl[$urandom_range(0, rule_tbl.size() - 1)].f;
      if (rf.src_ip != '0) p.src_ip = rf.src_ip;
      if (rf.dst_ip != '0) p.dst_ip = rf.dst_ip;
      if (rf.sport != '0) p.sport = rf.sport;
      if (rf.dport != '0) p.dport = rf.dport;
      if (rf.protocol != '0) p.protocol = rf.protocol;
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 4))
          0: p.src_ip[$urandom_range(0, 31)] ^= 1'b1;
          1: p.dst_ip[$urandom_range(0, 31)] ^= 1'b1;
          2: p.sport[$urandom_range(0, 15)] ^= 1'b1;
          3: p.dport[$urandom_range(0, 15)] ^= 1'b1;
          default: p.protocol[$urandom_range(0, 7)] ^= 1'b1;
        endcase
      end
    end
    return p;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (!idle_on) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Offers one request, holds it steady while stalled, and records the
  // predicted response at the edge where it is taken. Called at a rising edge.
  task automatic send_request(input in_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_rsp_q.insert(awaited_rsp_q.size(), rule_table_step(r));
  endtask

  // The sender holds off until every predicted response has come back.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls and the checker.
  // ---------------------------------------------------------------------------

  // Most cycles run free; some stall for a few cycles, a few for a long while.
  always @(posedge clk_i) begin
    if (!idle_on) begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 12) begin
        stall_left <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else if (stall_roll < 14) begin
        stall_left <= $urandom_range(30, 200);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Each accepted response is compared field by field with the oldest
  // prediction; a response with no prediction waiting is an error in itself.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_rsp_q.size() == 0) begin
        report_error($sformatf("response 0x%0h with no request outstanding", out_rsp_o));
      end else begin
        want_rsp = awaited_rsp_q.pop_front();
        check_field("status", 64'(out_rsp_o.status), 64'(want_rsp.status));
        check_field("result_action", 64'(out_rsp_o.result_action),
                    64'(want_rsp.result_action));
        check_field("hit", 64'(out_rsp_o.hit), 64'(want_rsp.hit));
        check_field("assigned_id", out_rsp_o.assigned_id, want_rsp.assigned_id);
        check_field("out_src_ip", 64'(out_rsp_o.out_src_ip), 64'(want_rsp.out_src_ip));
        check_field("out_dst_ip", 64'(out_rsp_o.out_dst_ip), 64'(want_rsp.out_dst_ip));
        check_field("out_src_port", 64'(out_rsp_o.out_src_port),
                    64'(want_rsp.out_src_port));
        check_field("out_dst_port", 64'(out_rsp_o.out_dst_port),
                    64'(want_rsp.out_dst_port));
        check_field("out_protocol", 64'(out_rsp_o.out_protocol),
                    64'(want_rsp.out_protocol));
        check_field("count_of_rules", 64'(out_rsp_o.count_of_rules),
                    64'(want_rsp.count_of_rules));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Classify, get and remove against an empty table: nothing hits and no id is known.
  task automatic test_empty_table();
    send_request(make_req(OP_CLASSIFY, rand_id(), '0));
    send_request(make_req(OP_CLASSIFY, rand_id(), '1));
    send_request(make_req(OP_GET, 64'd0, random_fields(1'b0)));
    send_request(make_req(OP_REMOVE, '1, random_fields(1'b0)));
    send_request(make_req(OP_GET, id_counter, random_fields(1'b0)));
  endtask

  // Three rules in order: an exact rule with every field at its maximum, a
  // partly wildcarded rule whose action is pass, and a catch-all. The packets
  // probe first-match order, a hit that still returns pass, a near miss, and
  // removal from the middle and the end of the list.
  task automatic test_first_match_order();
    fields_t exact_f;
    fields_t pass_f;
    fields_t any_f;
    fields_t pkt;
    logic [63:0] exact_id;
    logic [63:0] pass_id;
    logic [63:0] any_id;
    // Field order: action, source and destination address, ports, protocol.
    exact_f = '1;
    pass_f = {4'h0, 32'h0A00_0001, 32'h0, 16'h0, 16'h0050, 8'h06};
    any_f = {4'h9, 104'h0};
    exact_id = id_counter;
    pass_id = id_counter + 64'd1;
    any_id = id_counter + 64'd2;
    send_request(make_req(OP_ADD, rand_id(), exact_f));
    send_request(make_req(OP_ADD, rand_id(), pass_f));
    send_request(make_req(OP_ADD, rand_id(), any_f));
    send_request(make_req(OP_CLASSIFY, rand_id(), exact_f));
    pkt = exact_f;
    pkt.protocol = 8'hFE;
    send_request(make_req(OP_CLASSIFY, rand_id(), pkt));
    pkt = {4'h3, 32'h0A00_0001, 32'hC0A8_0101, 16'hBEEF, 16'h0050, 8'h06};
    send_request(make_req(OP_CLASSIFY, rand_id(), pkt));
    send_request(make_req(OP_CLASSIFY, rand_id(), '0));
    send_request(make_req(OP_GET, exact_id, random_fields(1'b0)));
    send_request(make_req(OP_GET, pass_id, random_fields(1'b0)));
    send_request(make_req(OP_GET, any_id, random_fields(1'b0)));
    send_request(make_req(OP_REMOVE, pass_id, random_fields(1'b0)));
    send_request(make_req(OP_CLASSIFY, rand_id(), pkt));
    send_request(make_req(OP_GET, pass_id, random_fields(1'b0)));
    send_request(make_req(OP_REMOVE, pass_id, random_fields(1'b0)));
    send_request(make_req(OP_REMOVE, any_id, random_fields(1'b0)));
    send_request(make_req(OP_CLASSIFY, rand_id(), '0));
    send_request(make_req(OP_REMOVE, exact_id, random_fields(1'b0)));
  endtask

  // Fills the table, then checks that further adds are refused without using
  // up an id, that a freed slot can be reused, and empties most of it again.
  task automatic test_table_full();
    while (rule_tbl.size() < MAX_RULES) begin
      send_request(make_req(OP_ADD, rand_id(), random_fields(1'b1)));
    end
    wait_until_drained();
    send_request(make_req(OP_ADD, rand_id(), random_fields(1'b1)));
    send_request(make_req(OP_ADD, rand_id(), random_fields(1'b1)));
    send_request(make_req(OP_CLASSIFY, rand_id(), pick_packet()));
    send_request(make_req(OP_GET, rule_tbl[rule_tbl.size() - 1].id, random_fields(1'b0)));
    send_request(make_req(OP_GET, rule_tbl[0].id, random_fields(1'b0)));
    send_request(make_req(OP_REMOVE, rule_tbl[0].id, random_fields(1'b0)));
    send_request(make_req(OP_ADD, rand_id(), random_fields(1'b1)));
    send_request(make_req(OP_ADD, rand_id(), random_fields(1'b1)));
    send_request(make_req(OP_REMOVE, rule_tbl[rule_tbl.size() - 1].id, random_fields(1'b0)));
    while (rule_tbl.size() > 8) begin
      send_request(make_req(OP_REMOVE, rule_tbl[$urandom_range(0, rule_tbl.size() - 1)].id,
                            random_fields(1'b0)));
      send_request(make_req(OP_CLASSIFY, rand_id(), pick_packet()));
    end
  endtask

  // Random mix of operations with content that keeps hitting live rules. Adds
  // are favoured while the table is small and held back when it fills up.
  task automatic test_random_traffic(input int unsigned n);
    int unsigned add_w;
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      add_w = (rule_tbl.size() < 6) ? 50 : (rule_tbl.size() > 40) ? 10 : 25;
      sel = $urandom_range(0, 99);
      if (sel < add_w) begin
        send_request(make_req(OP_ADD, rand_id(), random_fields(1'b1)));
      end else if (sel < add_w + 20) begin
        send_request(make_req(OP_REMOVE, pick_id(), random_fields(1'b0)));
      end else if (sel < add_w + 35) begin
        send_request(make_req(OP_GET, pick_id(), random_fields(1'b0)));
      end else begin
        send_request(make_req(OP_CLASSIFY, rand_id(), pick_packet()));
      end
      // Now and then let everything drain and reconsider whether to idle.
      if (i % 100 == 99) begin
        idle_on <= ($urandom_range(0, 3) != 0);
        wait_until_drained();
      end
    end
  endtask

  // A stretch with requests offered every cycle and responses never stalled.
  task automatic test_back_to_back();
    idle_on <= 1'b0;
    wait_until_drained();
    test_random_traffic(60);
    idle_on <= 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_first_match_order();
    test_table_full();
    test_back_to_back();
    test_random_traffic(420);

    // Every request is in; wait for the last responses, then a little longer
    // so that any spurious extra response would still be seen.
    wait_until_drained();
    repeat (MAX_RULES + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hang: several times the slowest legal run.
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
